// ===== sv/i2cm_pkg.sv =====
package i2cm_pkg;

    // Bits in one transferred byte and the width of the bit counter.
    localparam int unsigned BYTE_BITS = 8;
    localparam int unsigned BIT_CNT_W = 4;

    // Command codes carried by a request.
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_WACK  = 3'd5,
        CMD_ACK   = 3'd6,
        CMD_NACK  = 3'd7
    } cmd_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_BUS_FREE   = 3'd0;
    localparam logic [2:0] REG_START_HOLD = 3'd1;
    localparam logic [2:0] REG_SCL_LOW    = 3'd2;
    localparam logic [2:0] REG_SCL_HIGH   = 3'd3;
    localparam logic [2:0] REG_STOP       = 3'd4;
    localparam logic [2:0] REG_DATA_SETUP = 3'd5;
    localparam logic [2:0] REG_ACK_TMO    = 3'd6;

    // Configuration reset values.
    localparam logic [15:0] RST_BUS_FREE   = 16'd10;
    localparam logic [15:0] RST_START_HOLD = 16'd10;
    localparam logic [15:0] RST_SCL_LOW    = 16'd20;
    localparam logic [15:0] RST_SCL_HIGH   = 16'd20;
    localparam logic [15:0] RST_STOP       = 16'd10;
    localparam logic [15:0] RST_DATA_SETUP = 16'd10;
    localparam logic [7:0]  RST_ACK_TMO    = 8'd250;

    // Bus sequencer phases.
    typedef enum logic [13:0] {
        PH_IDLE    = 14'b00000000000001,
        PH_ST_BUF  = 14'b00000000000010,
        PH_ST_HOLD = 14'b00000000000100,
        PH_SP_LOW  = 14'b00000000001000,
        PH_W_SETUP = 14'b00000000010000,
        PH_W_HIGH  = 14'b00000000100000,
        PH_W_LOW   = 14'b00000001000000,
        PH_R_LOW   = 14'b00000010000000,
        PH_R_HIGH  = 14'b00000100000000,
        PH_A_SETUP = 14'b00001000000000,
        PH_A_HIGH  = 14'b00010000000000,
        PH_A_POLL  = 14'b00100000000000,
        PH_K_LOW   = 14'b01000000000000,
        PH_K_HIGH  = 14'b10000000000000
    } phase_t;

    // Classified command, one flag per kind.
    typedef struct packed {
        logic start;
        logic stop;
        logic wr;
        logic rd;
        logic wack;
        logic ack;
        logic nack;
    } cmd_kind_t;

    // Request as it travels from the front to the engine.
    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  tx_byte;
        logic        sda_in;
    } item_t;

    // Result of one tick.
    typedef struct packed {
        logic        scl;
        logic        sda_out;
        logic        sda_drive;
        logic        busy_res;
        logic        done_res;
        logic [7:0]  rx_byte;
        logic        ack_error;
    } result_t;

    // Handshake between the request queue and the engine.
    typedef struct packed {
        logic valid;
        logic take;
    } link_t;

endpackage

// ===== sv/i2cm_fifo.sv =====
module i2cm_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    // Storage entries.
    always_ff @(posedge clk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_rd && !do_wr) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

// ===== sv/i2cm_front.sv =====
module i2cm_front #(
    parameter int unsigned DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         cmd,
    input  logic [7:0]         tx_byte,
    input  logic               sda_in,
    output i2cm_pkg::link_t    link_out,
    input  i2cm_pkg::link_t    link_in,
    output i2cm_pkg::item_t    item
);

    i2cm_pkg::item_t     item_in;
    i2cm_pkg::cmd_kind_t kind;
    logic                empty;

    // Classify the command code into one flag per kind.
    always_comb begin
        kind = '0;
        case (i2cm_pkg::cmd_t'(cmd))
            i2cm_pkg::CMD_NONE:  kind = '0;
            i2cm_pkg::CMD_START: kind.start = 1'b1;
            i2cm_pkg::CMD_STOP:  kind.stop = 1'b1;
            i2cm_pkg::CMD_WRITE: kind.wr = 1'b1;
            i2cm_pkg::CMD_READ:  kind.rd = 1'b1;
            i2cm_pkg::CMD_WACK:  kind.wack = 1'b1;
            i2cm_pkg::CMD_ACK:   kind.ack = 1'b1;
            i2cm_pkg::CMD_NACK:  kind.nack = 1'b1;
            default:             kind = '0;
        endcase
    end

    assign item_in.kind    = kind;
    assign item_in.tx_byte = tx_byte;
    assign item_in.sda_in  = sda_in;

    // Queue of classified requests in front of the engine.
    i2cm_fifo #(
        .WIDTH ($bits(i2cm_pkg::item_t)),
        .DEPTH (DEPTH)
    ) u_req_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (item_in),
        .full    (full),
        .rd_en   (link_in.take),
        .rd_data (item),
        .empty   (empty)
    );

    assign link_out.valid = !empty;
    assign link_out.take  = link_in.take;

endmodule

// ===== sv/i2cm_engine.sv =====
module i2cm_engine #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  i2cm_pkg::link_t     link_in,
    output i2cm_pkg::link_t     link_out,
    input  i2cm_pkg::item_t     item,
    input  logic                res_full,
    output logic                res_push,
    output i2cm_pkg::result_t   res
);

    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF >> (32 - COUNT_WIDTH);
    localparam logic [i2cm_pkg::BIT_CNT_W-1:0] LAST_BIT =
        i2cm_pkg::BIT_CNT_W'(i2cm_pkg::BYTE_BITS);

    // Clamp a delay register to the counter range, with zero taken as one tick.
    function automatic logic [COUNT_WIDTH-1:0] load_ticks(input logic [15:0] v);
        logic [31:0] t;
        t = {16'd0, v};
        if (t > CNT_MAX) begin
            t = CNT_MAX;
        end
        if (t == 32'd0) begin
            t = 32'd1;
        end
        return t[COUNT_WIDTH-1:0];
    endfunction

    // Configuration registers.
    logic [15:0] bus_free_reg;
    logic [15:0] start_hold_reg;
    logic [15:0] scl_low_reg;
    logic [15:0] scl_high_reg;
    logic [15:0] stop_reg;
    logic [15:0] data_setup_reg;
    logic [7:0]  ack_tmo_reg;

    // Engine state.
    i2cm_pkg::phase_t                phase_reg, phase_next;
    logic [i2cm_pkg::BIT_CNT_W-1:0]  bit_count_reg, bit_count_next;
    logic [7:0]                      shift_reg, shift_next;
    logic [COUNT_WIDTH-1:0]          delay_reg, delay_next;
    logic [7:0]                      poll_reg, poll_next;
    logic                            scl_reg, scl_next;
    logic                            sda_reg, sda_next;
    logic                            drive_reg, drive_next;
    logic [7:0]                      rx_reg, rx_next;
    logic                            error_reg, error_next;

    logic                            take;
    logic                            done;
    logic [COUNT_WIDTH-1:0]          delay_dec;
    logic [i2cm_pkg::BIT_CNT_W-1:0]  bit_inc;
    logic [8:0]                      poll_inc;

    assign take           = link_in.valid && !res_full;
    assign link_out.valid = link_in.valid;
    assign link_out.take  = take;
    assign res_push       = take;

    assign delay_dec = (delay_reg != '0) ? delay_reg - COUNT_WIDTH'(1) : delay_reg;
    assign bit_inc   = bit_count_reg + i2cm_pkg::BIT_CNT_W'(1);
    assign poll_inc  = {1'b0, poll_reg} + 9'd1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            bus_free_reg   <= i2cm_pkg::RST_BUS_FREE;
            start_hold_reg <= i2cm_pkg::RST_START_HOLD;
            scl_low_reg    <= i2cm_pkg::RST_SCL_LOW;
            scl_high_reg   <= i2cm_pkg::RST_SCL_HIGH;
            stop_reg       <= i2cm_pkg::RST_STOP;
            data_setup_reg <= i2cm_pkg::RST_DATA_SETUP;
            ack_tmo_reg    <= i2cm_pkg::RST_ACK_TMO;
        end
        else if (cfg_we) begin
            case (cfg_index)
                i2cm_pkg::REG_BUS_FREE:   bus_free_reg   <= cfg_data;
                i2cm_pkg::REG_START_HOLD: start_hold_reg <= cfg_data;
                i2cm_pkg::REG_SCL_LOW:    scl_low_reg    <= cfg_data;
                i2cm_pkg::REG_SCL_HIGH:   scl_high_reg   <= cfg_data;
                i2cm_pkg::REG_STOP:       stop_reg       <= cfg_data;
                i2cm_pkg::REG_DATA_SETUP: data_setup_reg <= cfg_data;
                i2cm_pkg::REG_ACK_TMO:    ack_tmo_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Next state for one tick.
    always_comb begin
        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        delay_next     = delay_reg;
        poll_next      = poll_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        drive_next     = drive_reg;
        rx_next        = rx_reg;
        error_next     = error_reg;
        done           = 1'b0;

        if (take) begin
            case (phase_reg)
                // Idle: start a new command.
                i2cm_pkg::PH_IDLE: begin
                    if (item.kind.start) begin
                        drive_next = 1'b1;
                        sda_next   = 1'b1;
                        scl_next   = 1'b1;
                        phase_next = i2cm_pkg::PH_ST_BUF;
                        delay_next = load_ticks(bus_free_reg);
                    end
                    else if (item.kind.stop) begin
                        drive_next = 1'b1;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        phase_next = i2cm_pkg::PH_SP_LOW;
                        delay_next = load_ticks(stop_reg);
                    end
                    else if (item.kind.wr) begin
                        drive_next     = 1'b1;
                        scl_next       = 1'b0;
                        bit_count_next = '0;
                        sda_next       = item.tx_byte[7];
                        shift_next     = {item.tx_byte[6:0], 1'b0};
                        phase_next     = i2cm_pkg::PH_W_SETUP;
                        delay_next     = load_ticks(data_setup_reg);
                    end
                    else if (item.kind.rd) begin
                        drive_next     = 1'b0;
                        scl_next       = 1'b0;
                        shift_next     = '0;
                        bit_count_next = '0;
                        phase_next     = i2cm_pkg::PH_R_LOW;
                        delay_next     = load_ticks(scl_low_reg);
                    end
                    else if (item.kind.wack) begin
                        sda_next   = 1'b1;
                        phase_next = i2cm_pkg::PH_A_SETUP;
                        delay_next = load_ticks(data_setup_reg);
                    end
                    else if (item.kind.ack || item.kind.nack) begin
                        scl_next   = 1'b0;
                        drive_next = 1'b1;
                        sda_next   = item.kind.nack;
                        phase_next = i2cm_pkg::PH_K_LOW;
                        delay_next = load_ticks(scl_low_reg);
                    end
                end

                // Acknowledge polling: a low sample ends it, high samples count.
                i2cm_pkg::PH_A_POLL: begin
                    if (!item.sda_in) begin
                        scl_next   = 1'b0;
                        error_next = 1'b0;
                        phase_next = i2cm_pkg::PH_IDLE;
                        delay_next = '0;
                        done       = 1'b1;
                    end
                    else if (poll_inc > {1'b0, ack_tmo_reg}) begin
                        error_next = 1'b1;
                        phase_next = i2cm_pkg::PH_IDLE;
                        delay_next = '0;
                        done       = 1'b1;
                    end
                    else begin
                        poll_next = poll_inc[7:0];
                    end
                end

                // Timed phases: count down, then move on.
                default: begin
                    delay_next = delay_dec;
                    if (delay_dec == '0) begin
                        case (phase_reg)
                            i2cm_pkg::PH_ST_BUF: begin
                                sda_next   = 1'b0;
                                phase_next = i2cm_pkg::PH_ST_HOLD;
                                delay_next = load_ticks(start_hold_reg);
                            end
                            i2cm_pkg::PH_ST_HOLD: begin
                                scl_next   = 1'b0;
                                phase_next = i2cm_pkg::PH_IDLE;
                                done       = 1'b1;
                            end
                            i2cm_pkg::PH_SP_LOW: begin
                                scl_next   = 1'b1;
                                sda_next   = 1'b1;
                                phase_next = i2cm_pkg::PH_IDLE;
                                done       = 1'b1;
                            end
                            i2cm_pkg::PH_W_SETUP: begin
                                scl_next   = 1'b1;
                                phase_next = i2cm_pkg::PH_W_HIGH;
                                delay_next = load_ticks(scl_high_reg);
                            end
                            i2cm_pkg::PH_W_HIGH: begin
                                scl_next   = 1'b0;
                                phase_next = i2cm_pkg::PH_W_LOW;
                                delay_next = load_ticks(scl_low_reg);
                            end
                            i2cm_pkg::PH_W_LOW: begin
                                bit_count_next = bit_inc;
                                if (bit_inc >= LAST_BIT) begin
                                    phase_next = i2cm_pkg::PH_IDLE;
                                    done       = 1'b1;
                                end
                                else begin
                                    sda_next   = shift_reg[7];
                                    shift_next = {shift_reg[6:0], 1'b0};
                                    phase_next = i2cm_pkg::PH_W_SETUP;
                                    delay_next = load_ticks(data_setup_reg);
                                end
                            end
                            i2cm_pkg::PH_R_LOW: begin
                                scl_next   = 1'b1;
                                shift_next = {shift_reg[6:0], item.sda_in};
                                phase_next = i2cm_pkg::PH_R_HIGH;
                                delay_next = load_ticks(scl_high_reg);
                            end
                            i2cm_pkg::PH_R_HIGH: begin
                                bit_count_next = bit_inc;
                                if (bit_inc >= LAST_BIT) begin
                                    rx_next    = shift_reg;
                                    phase_next = i2cm_pkg::PH_IDLE;
                                    done       = 1'b1;
                                end
                                else begin
                                    scl_next   = 1'b0;
                                    phase_next = i2cm_pkg::PH_R_LOW;
                                    delay_next = load_ticks(scl_low_reg);
                                end
                            end
                            i2cm_pkg::PH_A_SETUP: begin
                                drive_next = 1'b0;
                                scl_next   = 1'b1;
                                phase_next = i2cm_pkg::PH_A_HIGH;
                                delay_next = load_ticks(scl_high_reg);
                            end
                            i2cm_pkg::PH_A_HIGH: begin
                                poll_next  = '0;
                                phase_next = i2cm_pkg::PH_A_POLL;
                            end
                            i2cm_pkg::PH_K_LOW: begin
                                scl_next   = 1'b1;
                                phase_next = i2cm_pkg::PH_K_HIGH;
                                delay_next = load_ticks(scl_high_reg);
                            end
                            i2cm_pkg::PH_K_HIGH: begin
                                scl_next   = 1'b0;
                                phase_next = i2cm_pkg::PH_IDLE;
                                done       = 1'b1;
                            end
                            default: begin
                                phase_next = i2cm_pkg::PH_IDLE;
                                delay_next = '0;
                                done       = 1'b1;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    // Result of this tick, built from the updated state.
    assign res.scl       = scl_next;
    assign res.sda_out   = sda_next;
    assign res.sda_drive = drive_next;
    assign res.busy_res  = (phase_next != i2cm_pkg::PH_IDLE);
    assign res.done_res  = done;
    assign res.rx_byte   = rx_next;
    assign res.ack_error = error_next;

    // State registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg     <= i2cm_pkg::PH_IDLE;
            bit_count_reg <= '0;
            shift_reg     <= '0;
            delay_reg     <= '0;
            poll_reg      <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            drive_reg     <= 1'b1;
            rx_reg        <= '0;
            error_reg     <= 1'b0;
        end
        else begin
            phase_reg     <= phase_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            delay_reg     <= delay_next;
            poll_reg      <= poll_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            drive_reg     <= drive_next;
            rx_reg        <= rx_next;
            error_reg     <= error_next;
        end
    end

endmodule

// ===== sv/i2c_master_bit_engine.sv =====
// A request accepted into the request queue is taken by the engine once the result queue
// has room, and its result enters the result queue as it is taken, ready to be popped.
// Throughput: one request per cycle while the result queue is not full, one result per request,
// from the bus sequencer between a two-entry request queue and a two-entry result queue.
// Reset (rst_n low, asynchronous): queues empty, configuration at defaults,
// sequencer idle with SCL, SDA and SDA drive high.
module i2c_master_bit_engine #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  cmd,
    input  logic [7:0]  tx_byte,
    input  logic        sda_in,
    input  logic        pop,
    output logic        empty,
    output logic        scl,
    output logic        sda_out,
    output logic        sda_drive,
    output logic        busy_res,
    output logic        done_res,
    output logic [7:0]  rx_byte,
    output logic        ack_error
);

    localparam int unsigned QUEUE_DEPTH = 2;

    i2cm_pkg::link_t   req_link;
    i2cm_pkg::link_t   eng_link;
    i2cm_pkg::item_t   item;
    i2cm_pkg::result_t res_in;
    i2cm_pkg::result_t res_out;
    logic              res_full;
    logic              res_push;

    // Front: accepts and classifies requests.
    i2cm_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .cmd      (cmd),
        .tx_byte  (tx_byte),
        .sda_in   (sda_in),
        .link_out (req_link),
        .link_in  (eng_link),
        .item     (item)
    );

    // Back: the timed bus sequencer.
    i2cm_engine #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .link_in   (req_link),
        .link_out  (eng_link),
        .item      (item),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // Result queue toward the consumer.
    i2cm_fifo #(
        .WIDTH ($bits(i2cm_pkg::result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign scl       = res_out.scl;
    assign sda_out   = res_out.sda_out;
    assign sda_drive = res_out.sda_drive;
    assign busy_res  = res_out.busy_res;
    assign done_res  = res_out.done_res;
    assign rx_byte   = res_out.rx_byte;
    assign ack_error = res_out.ack_error;

endmodule

// ===== sv/i2cm_checker.sv =====
module i2cm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       pop,
    input logic       empty,
    input logic       scl,
    input logic       sda_out,
    input logic       sda_drive,
    input logic       busy_res,
    input logic       done_res,
    input logic [7:0] rx_byte,
    input logic       ack_error
);

    // A finishing tick is never also a busy tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(busy_res && done_res))
    else $error("result shows busy and done together");

    // A waiting result that is not popped stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable({scl, sda_out, sda_drive, busy_res,
                                                  done_res, rx_byte, ack_error})))
    else $error("waiting result changed or vanished");

    // Nothing is waiting right after reset is released.
    assert property (@(posedge clk)
        $rose(rst_n) |-> empty)
    else $error("result present right after reset");

endmodule

bind i2c_master_bit_engine i2cm_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop       (pop),
    .empty     (empty),
    .scl       (scl),
    .sda_out   (sda_out),
    .sda_drive (sda_drive),
    .busy_res  (busy_res),
    .done_res  (done_res),
    .rx_byte   (rx_byte),
    .ack_error (ack_error)
);
